/* rtl/core/due_time_priority_queue_core_defines.svh */
// ----------------------------------------------------------------------------
// Due-time priority queue: assertion macros
// Shared concurrent assertion wrappers, clocked on an explicit or the block clock.
// ----------------------------------------------------------------------------
`ifndef DUE_TIME_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define DUE_TIME_PRIORITY_QUEUE_CORE_DEFINES_SVH

// Generic form: explicit clock and reset.
`define DTPQ_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Block form: uses the block's clock and reset names.
`define DTPQ_ASSERT(label, prop, msg) \
   `DTPQ_ASSERT_CLK(label, clock, reset, prop, msg)

`endif

/* rtl/core/dtpq_pkg.sv */
// ----------------------------------------------------------------------------
// Due-time priority queue package
// Default sizes, field widths, operation/status codes and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dtpq_pkg;

   localparam int DEPTH_DEFAULT     = 16;
   localparam int TIME_BITS_DEFAULT = 48;

   localparam int TAG_W   = 16;
   localparam int PRIO_W  = 8;
   localparam int TRIES_W = 8;
   localparam int LIMIT_W = 5;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

   // entry layout, lowest bits first: tag, priority, attempts, due, stamp
   localparam int TAG_LO   = 0;
   localparam int PRIO_LO  = TAG_LO + TAG_W;
   localparam int TRIES_LO = PRIO_LO + PRIO_W;
   localparam int DUE_LO   = TRIES_LO + TRIES_W;

   typedef enum logic [1:0] {
      OP_ENQUEUE  = 2'd0,
      OP_DEQUEUE  = 2'd1,
      OP_SHUTDOWN = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK   = 2'd0,
      STAT_FULL = 2'd1,
      STAT_SHUT = 2'd2,
      STAT_NONE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      CMD_HOLD,
      CMD_INSERT,
      CMD_ROTATE
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type        cmd;
      logic                drop;
      logic [PRIO_W-1:0]   new_prio;
   } cell_ctrl_type;

endpackage

`default_nettype wire

/* rtl/core/dtpq_cell.sv */
// ----------------------------------------------------------------------------
// Due-time priority queue cell
// Holds one entry; inserts in priority order or rotates the ring by one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dtpq_cell #(
   parameter int INDEX     = 0,
   parameter int DEPTH     = dtpq_pkg::DEPTH_DEFAULT,
   parameter int TIME_BITS = dtpq_pkg::TIME_BITS_DEFAULT
) (
   input  wire                                   clock,
   input  wire  dtpq_pkg::cell_ctrl_type         ctrl,
   input  wire  [$clog2(DEPTH+1)-1:0]            len,
   input  wire  [dtpq_pkg::DUE_LO+2*TIME_BITS-1:0] new_data,
   input  wire  [dtpq_pkg::DUE_LO+2*TIME_BITS-1:0] left_data,
   input  wire                                   left_stay,
   input  wire  [dtpq_pkg::DUE_LO+2*TIME_BITS-1:0] right_data,
   input  wire  [dtpq_pkg::DUE_LO+2*TIME_BITS-1:0] head_data,
   output logic [dtpq_pkg::DUE_LO+2*TIME_BITS-1:0] data_o,
   output logic                                  stay_o
);

   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int ENTRY_W = dtpq_pkg::DUE_LO + 2 * TIME_BITS;
   localparam logic [CNT_W-1:0] IDX  = CNT_W'(INDEX);
   localparam logic [CNT_W-1:0] NEXT = CNT_W'(INDEX + 1);

   logic [ENTRY_W-1:0] data_ff, data_in;
   logic               occupied;

   assign occupied = (IDX < len);
   assign stay_o   = occupied &&
                     (data_ff[dtpq_pkg::PRIO_LO +: dtpq_pkg::PRIO_W] >= ctrl.new_prio);
   assign data_o   = data_ff;

   always_comb begin
      data_in = data_ff;
      case (ctrl.cmd)
         dtpq_pkg::CMD_INSERT: begin
            // first cell past the kept prefix takes the new word, the rest shift down
            if (!stay_o) begin
               data_in = left_stay ? new_data : left_data;
            end
         end
         dtpq_pkg::CMD_ROTATE: begin
            if (NEXT < len) begin
               data_in = right_data;
            end else if (NEXT == len && !ctrl.drop) begin
               data_in = head_data;
            end
         end
         default: data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

`default_nettype wire

/* rtl/core/due_time_priority_queue_core.sv */
// ----------------------------------------------------------------------------
// Due-time priority queue core
// Bounded queue of message handles in descending priority order, FIFO among
// equal priorities, held in a row of cells. On an enqueue all cells compare
// priority in parallel and the entries behind the insert point move one cell
// down in a single step. On a dequeue the ring of cells rotates once through
// cell 0, which is tested against now_time, dropping the first due entry and
// tracking the earliest due time. One word is worked on at a time; the result
// register lets the next word be taken while a result waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "due_time_priority_queue_core_defines.svh"

module due_time_priority_queue_core #(
   parameter int DEPTH     = dtpq_pkg::DEPTH_DEFAULT,
   parameter int TIME_BITS = dtpq_pkg::TIME_BITS_DEFAULT
) (
   input  wire                                    clock,
   input  wire                                    reset,
   // config
   input  wire                                    csr_wen,
   input  wire  [dtpq_pkg::LIMIT_W-1:0]           csr_wdata,   // capacity_limit
   // request
   input  wire                                    req_tvalid,
   output logic                                   req_tready,
   // priority_req, attempts, due_time, now_time, message_tag
   input  wire  [((32+2*TIME_BITS+7)/8)*8-1:0]    req_tdata,
   input  wire  [1:0]                             req_tuser,   // operation
   // response
   output logic                                   rsp_tvalid,
   input  wire                                    rsp_tready,
   // out_tag, out_priority, out_attempts, out_due, out_enqueued,
   // earliest_pending, entry_count
   output logic [((32+3*TIME_BITS+$clog2(DEPTH+1)+7)/8)*8-1:0] rsp_tdata,
   output logic [1:0]                             rsp_tuser    // status
);

   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int ENTRY_W  = dtpq_pkg::DUE_LO + 2 * TIME_BITS;
   localparam int RSP_BITS = 32 + 3 * TIME_BITS + CNT_W;
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;
   localparam int LIM_W    = (CNT_W > dtpq_pkg::LIMIT_W) ? CNT_W : dtpq_pkg::LIMIT_W;
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

   dtpq_pkg::state_type    state_ff, state_in;
   dtpq_pkg::op_type       op_ff, op_in;
   dtpq_pkg::status_type   res_status_ff, res_status_in;
   dtpq_pkg::status_type   rsp_status_ff, rsp_status_in;
   dtpq_pkg::cell_ctrl_type cell_ctrl;

   logic [ENTRY_W-1:0]    new_ff, new_in;
   logic [TIME_BITS-1:0]  now_ff, now_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      steps_ff, steps_in;
   logic                  shut_ff, shut_in;
   logic [dtpq_pkg::LIMIT_W-1:0] limit_ff, limit_in;
   logic                  found_ff, found_in;
   logic [TIME_BITS-1:0]  min_ff, min_in;
   logic [ENTRY_W-1:0]    got_ff, got_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_BITS-1:0]   rsp_data_ff, rsp_data_in;

   logic [ENTRY_W-1:0]    cell_q [DEPTH];
   logic                  cell_stay [DEPTH];
   logic [TIME_BITS-1:0]  head_due;
   logic                  take;
   logic                  full;
   logic                  rsp_free;

   // ---------------------------------------------------------------- cells
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      dtpq_cell #(
         .INDEX     (g),
         .DEPTH     (DEPTH),
         .TIME_BITS (TIME_BITS)
      ) u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .len        (count_ff),
         .new_data   (new_ff),
         .left_data  ((g == 0) ? new_ff : cell_q[(g == 0) ? 0 : g-1]),
         .left_stay  ((g == 0) ? 1'b0 : cell_stay[(g == 0) ? 0 : g-1]),
         .right_data (cell_q[(g == DEPTH-1) ? 0 : g+1]),
         .head_data  (cell_q[0]),
         .data_o     (cell_q[g]),
         .stay_o     (cell_stay[g])
      );
   end

   assign head_due = cell_q[0][dtpq_pkg::DUE_LO +: TIME_BITS];
   assign take     = (head_due <= now_ff) && !found_ff;
   assign full     = (LIM_W'(count_ff) >= LIM_W'(limit_ff)) || (count_ff == DEPTH_C);
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   assign req_tready = (state_ff == dtpq_pkg::S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = RSP_W'(rsp_data_ff);

   // ---------------------------------------------------------------- control
   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      new_in         = new_ff;
      now_in         = now_ff;
      count_in       = count_ff;
      steps_in       = steps_ff;
      shut_in        = shut_ff;
      limit_in       = csr_wen ? csr_wdata : limit_ff;
      found_in       = found_ff;
      min_in         = min_ff;
      got_in         = got_ff;
      res_status_in  = res_status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_status_in  = rsp_status_ff;
      rsp_data_in    = rsp_data_ff;
      cell_ctrl.cmd      = dtpq_pkg::CMD_HOLD;
      cell_ctrl.drop     = 1'b0;
      cell_ctrl.new_prio = new_ff[dtpq_pkg::PRIO_LO +: dtpq_pkg::PRIO_W];

      unique case (state_ff)
         dtpq_pkg::S_IDLE: begin
            if (req_tvalid) begin
               op_in    = dtpq_pkg::op_type'(req_tuser);
               now_in   = req_tdata[16+TIME_BITS +: TIME_BITS];
               new_in   = {req_tdata[16+TIME_BITS +: TIME_BITS],
                           req_tdata[16 +: TIME_BITS],
                           req_tdata[15:8],
                           req_tdata[7:0],
                           req_tdata[16+2*TIME_BITS +: dtpq_pkg::TAG_W]};
               state_in = dtpq_pkg::S_EXEC;
            end
         end
         dtpq_pkg::S_EXEC: begin
            found_in      = 1'b0;
            min_in        = '0;
            res_status_in = dtpq_pkg::STAT_OK;
            state_in      = dtpq_pkg::S_DONE;
            case (op_ff)
               dtpq_pkg::OP_ENQUEUE: begin
                  if (shut_ff) begin
                     res_status_in = dtpq_pkg::STAT_SHUT;
                  end else if (full) begin
                     res_status_in = dtpq_pkg::STAT_FULL;
                  end else begin
                     cell_ctrl.cmd = dtpq_pkg::CMD_INSERT;
                     count_in      = count_ff + ONE_C;
                  end
               end
               dtpq_pkg::OP_DEQUEUE: begin
                  if (count_ff == '0) begin
                     res_status_in = shut_ff ? dtpq_pkg::STAT_SHUT : dtpq_pkg::STAT_NONE;
                  end else begin
                     min_in   = '1;
                     steps_in = count_ff;
                     state_in = dtpq_pkg::S_SCAN;
                  end
               end
               dtpq_pkg::OP_SHUTDOWN: begin
                  shut_in = 1'b1;
               end
               default: res_status_in = dtpq_pkg::STAT_OK;
            endcase
         end
         dtpq_pkg::S_SCAN: begin
            cell_ctrl.cmd  = dtpq_pkg::CMD_ROTATE;
            cell_ctrl.drop = take;
            if (head_due < min_ff) begin
               min_in = head_due;
            end
            if (take) begin
               got_in   = cell_q[0];
               found_in = 1'b1;
               count_in = count_ff - ONE_C;
            end
            steps_in = steps_ff - ONE_C;
            if (steps_ff == ONE_C) begin
               state_in = dtpq_pkg::S_DONE;
               if (found_ff || take) begin
                  res_status_in = dtpq_pkg::STAT_OK;
               end else begin
                  res_status_in = shut_ff ? dtpq_pkg::STAT_SHUT : dtpq_pkg::STAT_NONE;
               end
            end
         end
         dtpq_pkg::S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_data_in   = {count_ff,
                                (res_status_ff == dtpq_pkg::STAT_NONE) ?
                                   min_ff : {TIME_BITS{1'b0}},
                                found_ff ? got_ff : {ENTRY_W{1'b0}}};
               state_in      = dtpq_pkg::S_IDLE;
            end
         end
         default: state_in = dtpq_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dtpq_pkg::S_IDLE;
         count_ff     <= '0;
         steps_ff     <= '0;
         shut_ff      <= 1'b0;
         limit_ff     <= dtpq_pkg::LIMIT_RESET;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         steps_ff     <= steps_in;
         shut_ff      <= shut_in;
         limit_ff     <= limit_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      new_ff        <= new_in;
      now_ff        <= now_in;
      min_ff        <= min_in;
      got_ff        <= got_in;
      res_status_ff <= res_status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // ---------------------------------------------------------------- checks
   `DTPQ_ASSERT(a_count_bound, count_ff <= DEPTH_C, "entry count above depth")
   `DTPQ_ASSERT(a_scan_steps, state_ff == dtpq_pkg::S_SCAN |-> steps_ff != '0, "scan with no steps left")
   `DTPQ_ASSERT(a_accept_exec, req_tvalid && req_tready |=> state_ff == dtpq_pkg::S_EXEC, "accepted word not executed")
   `DTPQ_ASSERT(a_count_step, 1'b1 |=> (count_ff == $past(count_ff) || count_ff == $past(count_ff) + ONE_C || count_ff == $past(count_ff) - ONE_C), "entry count jumped")

endmodule

`default_nettype wire

/* bench/due_time_priority_queue_core_tb.sv */
// ----------------------------------------------------------------------------
// Due-time priority queue core testbench
// Drives enqueue, dequeue, shutdown and reserved-code words into the core
// under several capacity limits and handshake pacing phases. A scoreboard
// model of the ordered entry store predicts each response word, and the
// responses are checked field by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module due_time_priority_queue_core_tb;

   localparam int DEPTH   = dtpq_pkg::DEPTH_DEFAULT;
   localparam int TBITS   = dtpq_pkg::TIME_BITS_DEFAULT;
   localparam int PRIO_W  = dtpq_pkg::PRIO_W;
   localparam int TRIES_W = dtpq_pkg::TRIES_W;
   localparam int TAG_W   = dtpq_pkg::TAG_W;
   localparam int LIMIT_W = dtpq_pkg::LIMIT_W;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int REQ_W   = ((32 + 2 * TBITS + 7) / 8) * 8;
   localparam int RSP_W   = ((32 + 3 * TBITS + CNT_W + 7) / 8) * 8;
   localparam logic [1:0] OP_RESERVED = 2'd3;

   typedef logic [TBITS-1:0] tick_type;
   localparam tick_type TICK_MAX = '1;

   typedef struct packed {
      logic [1:0]         op;
      logic [PRIO_W-1:0]  prio;
      logic [TRIES_W-1:0] tries;
      tick_type           due;
      tick_type           now;
      logic [TAG_W-1:0]   tag;
   } req_word_type;

   typedef struct packed {
      logic [TAG_W-1:0]   tag;
      logic [PRIO_W-1:0]  prio;
      logic [TRIES_W-1:0] tries;
      tick_type           due;
      tick_type           stamp;
   } slot_type;

   typedef struct packed {
      dtpq_pkg::status_type status;
      logic [TAG_W-1:0]   tag;
      logic [PRIO_W-1:0]  prio;
      logic [TRIES_W-1:0] tries;
      tick_type           due;
      tick_type           enq;
      tick_type           earliest;
      logic [CNT_W-1:0]   count;
   } reply_type;

   typedef enum logic [1:0] {
      STEP_WORD,
      STEP_LIMIT,
      STEP_PACE
   } step_kind_type;

   typedef struct {
      step_kind_type      kind;
      req_word_type       w;
      logic [LIMIT_W-1:0] limit;
      int                 send_gap;
      int                 recv_gap;
   } step_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_wen = 1'b0;
   logic [LIMIT_W-1:0]   csr_wdata = '0;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata = '0;   // priority, attempts, due, now, tag
   logic [1:0]           req_tuser = '0;   // operation
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;        // tag, priority, attempts, due, enqueued,
                                           // earliest pending, entry count
   logic [1:0]           rsp_tuser;        // status

   step_type             op_backlog[$];
   reply_type            queued_replies[$];
   req_word_type         word_in_flight;
   int                   send_gap_pct = 0;
   int                   recv_gap_pct = 0;
   int                   fault_count = 0;
   tick_type             sim_tick = '0;

   slot_type             model_slots[$];
   bit                   model_shut = 1'b0;
   logic [LIMIT_W-1:0]   model_limit = dtpq_pkg::LIMIT_RESET;

   due_time_priority_queue_core #(
      .DEPTH(DEPTH),
      .TIME_BITS(TBITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .csr_wen(csr_wen),
      .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ordered store: descending priority, FIFO among equals
   function automatic reply_type queue_model_step(req_word_type w);
      reply_type r;
      slot_type  s;
      int        lim;
      int        pos;
      int        hit;
      int        i;
      tick_type  low;
      r = '0;
      r.status = dtpq_pkg::STAT_OK;
      lim = (model_limit > DEPTH) ? DEPTH : model_limit;
      case (w.op)
         dtpq_pkg::OP_ENQUEUE: begin
            if (model_shut) begin
               r.status = dtpq_pkg::STAT_SHUT;
            end else if (model_slots.size() >= lim) begin
               r.status = dtpq_pkg::STAT_FULL;
            end else begin
               s.tag = w.tag;
               s.prio = w.prio;
               s.tries = w.tries;
               s.due = w.due;
               s.stamp = w.now;
               pos = 0;
               while (pos < model_slots.size() && model_slots[pos].prio >= s.prio)
                  pos++;
               model_slots.insert(pos, s);
            end
         end
         dtpq_pkg::OP_DEQUEUE: begin
            hit = -1;
            for (i = 0; i < model_slots.size() && hit < 0; i++)
               if (model_slots[i].due <= w.now)
                  hit = i;
            if (hit >= 0) begin
               s = model_slots[hit];
               model_slots.delete(hit);
               r.tag = s.tag;
               r.prio = s.prio;
               r.tries = s.tries;
               r.due = s.due;
               r.enq = s.stamp;
            end else if (model_shut) begin
               r.status = dtpq_pkg::STAT_SHUT;
            end else begin
               r.status = dtpq_pkg::STAT_NONE;
               low = '0;
               for (i = 0; i < model_slots.size(); i++)
                  if (i == 0 || model_slots[i].due < low)
                     low = model_slots[i].due;
               r.earliest = low;
            end
         end
         dtpq_pkg::OP_SHUTDOWN: begin
            model_shut = 1'b1;
         end
         default: ;
      endcase
      r.count = CNT_W'(model_slots.size());
      return r;
   endfunction

   function automatic tick_type rand_tick();
      return tick_type'({$urandom(), $urandom()});
   endfunction

   task automatic push_word(logic [1:0] op, logic [PRIO_W-1:0] prio,
                            logic [TRIES_W-1:0] tries, tick_type due, tick_type now,
                            logic [TAG_W-1:0] tag);
      step_type st;
      st.kind = STEP_WORD;
      st.w.op = op;
      st.w.prio = prio;
      st.w.tries = tries;
      st.w.due = due;
      st.w.now = now;
      st.w.tag = tag;
      st.limit = '0;
      st.send_gap = 0;
      st.recv_gap = 0;
      op_backlog.push_back(st);
   endtask

   task automatic push_limit(int value);
      step_type st;
      st.kind = STEP_LIMIT;
      st.w = '0;
      st.limit = LIMIT_W'(value);
      st.send_gap = 0;
      st.recv_gap = 0;
      op_backlog.push_back(st);
   endtask

   task automatic push_pace(int send_gap, int recv_gap);
      step_type st;
      st.kind = STEP_PACE;
      st.w = '0;
      st.limit = '0;
      st.send_gap = send_gap;
      st.recv_gap = recv_gap;
      op_backlog.push_back(st);
   endtask

   // due times cluster around a slowly advancing tick so that both due and
   // not-yet-due entries are common
   task automatic push_random(int count, int enq_pct, int shut_pct);
      int                roll;
      logic [1:0]        op;
      logic [PRIO_W-1:0] prio;
      tick_type          due;
      tick_type          now;
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(99) == 0)
            sim_tick = rand_tick();
         else
            sim_tick = sim_tick + tick_type'($urandom_range(6));
         roll = $urandom_range(99);
         if (roll < enq_pct)
            op = dtpq_pkg::OP_ENQUEUE;
         else if (roll < 96)
            op = dtpq_pkg::OP_DEQUEUE;
         else if (roll < 96 + shut_pct)
            op = dtpq_pkg::OP_SHUTDOWN;
         else
            op = OP_RESERVED;
         prio = ($urandom_range(99) < 60) ? PRIO_W'($urandom_range(3))
                                          : PRIO_W'($urandom_range(255));
         roll = $urandom_range(99);
         if (roll < 80)
            due = sim_tick + tick_type'($urandom_range(30)) - tick_type'(10);
         else if (roll < 92)
            due = rand_tick();
         else if (roll < 96)
            due = '0;
         else
            due = TICK_MAX;
         roll = $urandom_range(99);
         if (roll < 95)
            now = sim_tick;
         else if (roll < 98)
            now = rand_tick();
         else
            now = TICK_MAX;
         push_word(op, prio, TRIES_W'($urandom_range(255)), due, now,
                   TAG_W'($urandom_range(65535)));
      end
   endtask

   task automatic check_field(string name, tick_type want, tick_type got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fault_count++;
      end
   endtask

   always @(posedge clock) begin : driver
      logic     next_valid;
      logic     next_wen;
      step_type head;
      if (reset) begin
         req_tvalid <= 1'b0;
         csr_wen <= 1'b0;
      end else begin
         next_valid = req_tvalid;
         next_wen = 1'b0;
         if (req_tvalid && req_tready) begin
            queued_replies.push_back(queue_model_step(word_in_flight));
            next_valid = 1'b0;
         end
         if (!next_valid && !csr_wen && op_backlog.size() > 0) begin
            head = op_backlog[0];
            case (head.kind)
               STEP_PACE: begin
                  send_gap_pct <= head.send_gap;
                  recv_gap_pct <= head.recv_gap;
                  op_backlog.delete(0);
               end
               STEP_LIMIT: begin
                  // only once every issued word has been answered
                  if (queued_replies.size() == 0) begin
                     csr_wdata <= head.limit;
                     model_limit = head.limit;
                     next_wen = 1'b1;
                     op_backlog.delete(0);
                  end
               end
               default: begin
                  if ($urandom_range(99) >= send_gap_pct) begin
                     word_in_flight = head.w;
                     req_tdata <= {head.w.tag, head.w.now, head.w.due,
                                   head.w.tries, head.w.prio};
                     req_tuser <= head.w.op;
                     next_valid = 1'b1;
                     op_backlog.delete(0);
                  end
               end
            endcase
         end
         req_tvalid <= next_valid;
         csr_wen <= next_wen;
      end
   end

   always @(posedge clock) begin : monitor
      reply_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (queued_replies.size() == 0) begin
               $display("%0t: unexpected word, expected none, actual status %0d tdata %0h",
                        $time, rsp_tuser, rsp_tdata);
               fault_count++;
            end else begin
               want = queued_replies.pop_front();
               check_field("status", want.status, rsp_tuser);
               check_field("out_tag", want.tag, rsp_tdata[15:0]);
               check_field("out_priority", want.prio, rsp_tdata[23:16]);
               check_field("out_attempts", want.tries, rsp_tdata[31:24]);
               check_field("out_due", want.due, rsp_tdata[32 +: TBITS]);
               check_field("out_enqueued", want.enq, rsp_tdata[32 + TBITS +: TBITS]);
               check_field("earliest_pending", want.earliest,
                           rsp_tdata[32 + 2 * TBITS +: TBITS]);
               check_field("entry_count", want.count, rsp_tdata[32 + 3 * TBITS +: CNT_W]);
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_gap_pct);
      end
   end

   initial begin
      int seg_limit[8] = '{16, 31, 5, 0, 17, 2, 16, 8};
      int seg_enq[8] = '{55, 70, 50, 40, 50, 60, 45, 50};

      // directed: reset limit, empty/extreme/equal-priority cases, reserved code
      push_word(dtpq_pkg::OP_DEQUEUE, 8'h00, 8'h00, '0, '0, 16'h0000);
      push_word(dtpq_pkg::OP_ENQUEUE, 8'h00, 8'h00, '0, '0, 16'h0000);
      push_word(dtpq_pkg::OP_ENQUEUE, 8'hFF, 8'hFF, TICK_MAX, TICK_MAX, 16'hFFFF);
      push_word(dtpq_pkg::OP_ENQUEUE, 8'd7, 8'd1, tick_type'(100), tick_type'(50),
                16'h0001);
      push_word(dtpq_pkg::OP_ENQUEUE, 8'd7, 8'd2, tick_type'(5), tick_type'(60),
                16'h0002);
      push_word(dtpq_pkg::OP_ENQUEUE, 8'd7, 8'd3, tick_type'(3), tick_type'(70),
                16'h0003);
      push_word(OP_RESERVED, 8'hA5, 8'h5A, rand_tick(), rand_tick(), 16'hBEEF);
      push_word(dtpq_pkg::OP_DEQUEUE, 8'h00, 8'h00, '0, tick_type'(4), 16'h0000);
      push_word(dtpq_pkg::OP_DEQUEUE, 8'h00, 8'h00, '0, tick_type'(2), 16'h0000);
      push_word(dtpq_pkg::OP_DEQUEUE, 8'h00, 8'h00, '0, tick_type'(1), 16'h0000);
      push_word(dtpq_pkg::OP_DEQUEUE, 8'h00, 8'h00, '0, TICK_MAX, 16'h0000);
      push_word(dtpq_pkg::OP_DEQUEUE, 8'h00, 8'h00, '0, tick_type'(200), 16'h0000);
      push_word(dtpq_pkg::OP_DEQUEUE, 8'h00, 8'h00, '0, tick_type'(200), 16'h0000);
      push_word(dtpq_pkg::OP_DEQUEUE, 8'h00, 8'h00, '0, tick_type'(200), 16'h0000);
      push_limit(1);
      push_word(dtpq_pkg::OP_ENQUEUE, 8'd3, 8'd9, tick_type'(10), tick_type'(10),
                16'h00A0);
      push_word(dtpq_pkg::OP_ENQUEUE, 8'd4, 8'd9, tick_type'(10), tick_type'(10),
                16'h00A1);
      push_limit(0);
      push_word(dtpq_pkg::OP_ENQUEUE, 8'd5, 8'd9, tick_type'(10), tick_type'(10),
                16'h00A2);
      push_word(dtpq_pkg::OP_DEQUEUE, 8'h00, 8'h00, '0, TICK_MAX, 16'h0000);

      for (int seg = 0; seg < 8; seg++) begin
         case (seg % 4)
            0: push_pace(0, 0);
            1: push_pace(56, 0);
            2: push_pace(0, 56);
            default: push_pace(7, 7);
         endcase
         push_limit(seg_limit[seg]);
         push_random(135, seg_enq[seg], 0);
      end

      // drain, then shutdown behavior
      push_pace(0, 0);
      push_limit(16);
      repeat (DEPTH) push_word(dtpq_pkg::OP_DEQUEUE, 8'h00, 8'h00, '0, TICK_MAX, 16'h0000);
      push_word(dtpq_pkg::OP_ENQUEUE, 8'd9, 8'd1, tick_type'(10), tick_type'(5), 16'h1111);
      push_word(dtpq_pkg::OP_ENQUEUE, 8'd9, 8'd2, tick_type'(40), tick_type'(5), 16'h2222);
      push_word(dtpq_pkg::OP_SHUTDOWN, 8'h00, 8'h00, rand_tick(), rand_tick(), 16'h0000);
      push_word(dtpq_pkg::OP_ENQUEUE, 8'd9, 8'd3, '0, tick_type'(5), 16'h3333);
      push_word(dtpq_pkg::OP_DEQUEUE, 8'h00, 8'h00, '0, tick_type'(20), 16'h0000);
      push_word(dtpq_pkg::OP_DEQUEUE, 8'h00, 8'h00, '0, tick_type'(20), 16'h0000);
      push_word(dtpq_pkg::OP_SHUTDOWN, 8'hFF, 8'hFF, rand_tick(), rand_tick(), 16'hFFFF);
      push_word(dtpq_pkg::OP_DEQUEUE, 8'h00, 8'h00, '0, tick_type'(40), 16'h0000);
      push_word(dtpq_pkg::OP_DEQUEUE, 8'h00, 8'h00, '0, tick_type'(40), 16'h0000);
      push_pace(7, 7);
      push_random(60, 40, 2);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      do
         @(negedge clock);
      while (op_backlog.size() != 0 || req_tvalid || csr_wen || queued_replies.size() != 0);
      repeat (50) @(negedge clock);
      if (fault_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
